/* rtl/asdc_pkg.sv */
package asdc_pkg;

  localparam int PORTS      = 2;
  localparam int PORT_IDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RADIUS  = 2'd2;

  localparam logic [CFG_W-1:0] DEAD_ZONE_RST   = 7'd8;
  localparam logic [CFG_W-1:0] DEAD_OFFSET_RST = 7'd6;
  localparam logic [CFG_W-1:0] MAX_RADIUS_RST  = 7'd64;

  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 80;

  // both the square root and the divider produce one result bit per step
  localparam int ITER_STEPS = 16;
  localparam int CNT_W      = $clog2(ITER_STEPS);

  // largest magnitude the output can carry (127 * 256)
  localparam logic [14:0] MAG_LIMIT = 15'd32512;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COND,
    ST_SQUARE,
    ST_SQRT,
    ST_CHECK,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic cond;
    logic square;
    logic sqrt_step;
    logic check;
    logic div_step;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic connected;
    logic over;
  } status_t;

endpackage

/* rtl/analog_stick_deadzone_clamp_core.sv */
// from input to output valid: cond, square, the square root steps, check and fin inside
// the radius, the divider steps before fin when scaled onto it, cond then fin if disconnected
// one poll at a time: a new input can be taken in the cycle after the previous result is
// registered; the 16-step square root and the two 16-step dividers give one bit per cycle;
// the output register frees the input side
// reset (synchronous, rst high): idle, output empty, held buttons cleared, registers 8/6/64
module analog_stick_deadzone_clamp_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [asdc_pkg::IN_DATA_W-1:0]        s_tdata,   // raw_x, raw_y, buttons
  input  logic [asdc_pkg::IN_USER_W-1:0]        s_tuser,   // port, connected
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [asdc_pkg::OUT_DATA_W-1:0]       m_tdata,   // axis_x, axis_y, magnitude,
                                                           // pressed, held_out, zero pad
  output logic                                  m_tuser,   // port_out
  input  logic                                  cfg_write,
  input  logic [asdc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [asdc_pkg::CFG_W-1:0]            cfg_data
);

  asdc_pkg::cmd_t    cmd;
  asdc_pkg::status_t status;

  asdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .status    (status),
    .cmd       (cmd)
  );

  asdc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .cmd       (cmd),
    .status    (status),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

`ifndef SYNTH
  // a poll is worked on alone: no new transaction right after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a poll is in flight");

  // loading a result always presents it
  a_fin_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> m_tvalid)
    else $error("result loaded but output not valid");

  // magnitude never exceeds the largest radius
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[46:32] <= asdc_pkg::MAG_LIMIT))
    else $error("magnitude out of range");

  // the square root and the dividers never run while the input side is open
  a_busy_closed: assert property (@(posedge clk) disable iff (rst)
    (cmd.sqrt_step || cmd.div_step) |-> !s_tready)
    else $error("input open during iteration");
`endif

endmodule

/* rtl/asdc_sqrt.sv */
module asdc_sqrt (
  input  logic        clk,
  input  logic        load,
  input  logic        step,
  input  logic [15:0] radicand,
  output logic [15:0] root
);

  // floor(sqrt(radicand * 65536)), two radicand bits per step
  logic [15:0] src;
  logic [16:0] rem;
  logic [15:0] root_q;
  logic [18:0] t;
  logic [18:0] trial;
  logic        ge;

  always_comb begin
    t     = {rem, src[15:14]};
    trial = {1'b0, root_q, 2'b01};
    ge    = t >= trial;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      src    <= radicand;
      rem    <= '0;
      root_q <= '0;
    end else if (step) begin
      src <= {src[13:0], 2'b00};
      if (ge) begin
        rem    <= 17'(t - trial);
        root_q <= {root_q[14:0], 1'b1};
      end else begin
        rem    <= t[16:0];
        root_q <= {root_q[14:0], 1'b0};
      end
    end
  end

  assign root = root_q;

endmodule

/* rtl/asdc_div.sv */
module asdc_div (
  input  logic        clk,
  input  logic        load,
  input  logic        step,
  input  logic [14:0] dividend,
  input  logic [15:0] divisor,
  output logic [15:0] quotient
);

  // computes (dividend << 16) / divisor, the quotient is known to fit 16 bits
  logic [15:0] rem;
  logic [15:0] quo;
  logic [16:0] t;
  logic        ge;

  always_comb begin
    t  = {rem, 1'b0};
    ge = t >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= {1'b0, dividend};
      quo <= '0;
    end else if (step) begin
      if (ge) begin
        rem <= 16'(t - {1'b0, divisor});
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= t[15:0];
        quo <= {quo[14:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

/* rtl/asdc_dp.sv */
module asdc_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [asdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [asdc_pkg::CFG_W-1:0]        cfg_data,
  input  logic [asdc_pkg::IN_DATA_W-1:0]    in_data,   // raw_x, raw_y, buttons
  input  logic [asdc_pkg::IN_USER_W-1:0]    in_user,   // port, connected
  input  asdc_pkg::cmd_t                    cmd,
  output asdc_pkg::status_t                 status,
  output logic [asdc_pkg::OUT_DATA_W-1:0]   out_data,  // axis_x, axis_y, magnitude, pressed,
                                                       // held_out, zero pad
  output logic                              out_user   // port_out
);

  logic [asdc_pkg::CFG_W-1:0] dead_zone;
  logic [asdc_pkg::CFG_W-1:0] dead_offset;
  logic [asdc_pkg::CFG_W-1:0] max_radius;

  logic [15:0] held [asdc_pkg::PORTS];

  logic        port_q;
  logic        conn_q;
  logic [7:0]  raw_x;
  logic [7:0]  raw_y;
  logic [15:0] btn;
  logic [15:0] pressed;

  logic [7:0]  mag_x;
  logic [7:0]  mag_y;
  logic        neg_x;
  logic        neg_y;
  logic [15:0] sum_sq;
  logic [15:0] sum_sq_next;
  logic        over_q;

  logic [15:0] root;
  logic [15:0] quo_x;
  logic [15:0] quo_y;
  logic [14:0] prod_x;
  logic [14:0] prod_y;
  logic [13:0] rad_sq;
  logic [14:0] rad_q;

  logic                               in_port;
  logic                               in_valid_port;
  logic [asdc_pkg::PORT_IDX_W-1:0]    in_idx;
  logic [15:0]                        in_held;

  logic [15:0] axis_x;
  logic [15:0] axis_y;
  logic [14:0] mag_out;

  function automatic logic [7:0] abs8(logic [7:0] v);
    return v[7] ? 8'(8'd0 - v) : v;
  endfunction

  function automatic logic [7:0] dead_apply(logic [7:0] m, logic [6:0] dz, logic [6:0] off);
    if (m < {1'b0, dz}) begin
      return 8'd0;
    end else if (m > {1'b0, off}) begin
      return 8'(m - {1'b0, off});
    end else begin
      return 8'd0;
    end
  endfunction

  function automatic logic [15:0] scaled_axis(logic [15:0] q, logic [14:0] lim, logic neg);
    logic [14:0] c;
    c = (q > {1'b0, lim}) ? lim : q[14:0];
    return neg ? 16'(16'd0 - {1'b0, c}) : {1'b0, c};
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone   <= asdc_pkg::DEAD_ZONE_RST;
      dead_offset <= asdc_pkg::DEAD_OFFSET_RST;
      max_radius  <= asdc_pkg::MAX_RADIUS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        asdc_pkg::CFG_DEAD_ZONE:   dead_zone   <= cfg_data;
        asdc_pkg::CFG_DEAD_OFFSET: dead_offset <= cfg_data;
        asdc_pkg::CFG_MAX_RADIUS:  max_radius  <= cfg_data;
        default: ;
      endcase
    end
  end

  // button history, read and written when a poll is taken
  always_comb begin
    in_port       = in_user[0];
    in_valid_port = {31'd0, in_port} < 32'(asdc_pkg::PORTS);
    in_idx        = asdc_pkg::PORT_IDX_W'(in_port);
    in_held       = in_valid_port ? held[in_idx] : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < asdc_pkg::PORTS; i++) begin
        held[i] <= '0;
      end
    end else if (cmd.accept && in_valid_port) begin
      held[in_idx] <= in_user[1] ? in_data[31:16] : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      port_q  <= in_port;
      conn_q  <= in_user[1];
      raw_x   <= in_data[7:0];
      raw_y   <= in_data[15:8];
      btn     <= in_data[31:16];
      pressed <= in_data[31:16] & (in_data[31:16] ^ in_held);
    end
  end

  // dead zone per axis
  always_ff @(posedge clk) begin
    if (cmd.cond) begin
      mag_x <= dead_apply(abs8(raw_x), dead_zone, dead_offset);
      mag_y <= dead_apply(abs8(raw_y), dead_zone, dead_offset);
      neg_x <= raw_x[7];
      neg_y <= raw_y[7];
    end
  end

  assign sum_sq_next = 16'(mag_x * mag_x) + 16'(mag_y * mag_y);

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sum_sq <= sum_sq_next;
    end
  end

  asdc_sqrt u_sqrt (
    .clk      (clk),
    .load     (cmd.square),
    .step     (cmd.sqrt_step),
    .radicand (sum_sq_next),
    .root     (root)
  );

  assign rad_sq = 14'(max_radius * max_radius);
  assign rad_q  = {max_radius, 8'h00};
  assign prod_x = 15'(mag_x * max_radius);
  assign prod_y = 15'(mag_y * max_radius);

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      over_q <= sum_sq > {2'b00, rad_sq};
    end
  end

  asdc_div u_div_x (
    .clk      (clk),
    .load     (cmd.check),
    .step     (cmd.div_step),
    .dividend (prod_x),
    .divisor  (root),
    .quotient (quo_x)
  );

  asdc_div u_div_y (
    .clk      (clk),
    .load     (cmd.check),
    .step     (cmd.div_step),
    .dividend (prod_y),
    .divisor  (root),
    .quotient (quo_y)
  );

  always_comb begin
    status.connected = conn_q;
    status.over      = sum_sq > {2'b00, rad_sq};
  end

  always_comb begin
    if (over_q) begin
      axis_x  = scaled_axis(quo_x, rad_q, neg_x);
      axis_y  = scaled_axis(quo_y, rad_q, neg_y);
      mag_out = rad_q;
    end else begin
      axis_x  = {(neg_x ? 8'(8'd0 - mag_x) : mag_x), 8'h00};
      axis_y  = {(neg_y ? 8'(8'd0 - mag_y) : mag_y), 8'h00};
      mag_out = root[14:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_user <= port_q;
      if (conn_q) begin
        out_data <= {1'b0, btn, pressed, mag_out, axis_y, axis_x};
      end else begin
        out_data <= '0;
      end
    end
  end

endmodule

/* rtl/asdc_ctrl.sv */
module asdc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  asdc_pkg::status_t status,
  output asdc_pkg::cmd_t    cmd
);

  asdc_pkg::state_t           state;
  asdc_pkg::state_t           state_next;
  logic [asdc_pkg::CNT_W-1:0] cnt;
  logic [asdc_pkg::CNT_W-1:0] cnt_next;
  logic                       out_full;
  logic                       out_full_next;
  logic                       last_step;

  assign last_step = cnt == asdc_pkg::CNT_W'(asdc_pkg::ITER_STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= asdc_pkg::ST_IDLE;
      cnt      <= '0;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      asdc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = asdc_pkg::ST_COND;
        end
      end
      asdc_pkg::ST_COND: begin
        cmd.cond   = 1'b1;
        state_next = status.connected ? asdc_pkg::ST_SQUARE : asdc_pkg::ST_FIN;
      end
      asdc_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        cnt_next   = '0;
        state_next = asdc_pkg::ST_SQRT;
      end
      asdc_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (last_step) begin
          state_next = asdc_pkg::ST_CHECK;
        end
      end
      asdc_pkg::ST_CHECK: begin
        cmd.check  = 1'b1;
        cnt_next   = '0;
        state_next = status.over ? asdc_pkg::ST_DIV : asdc_pkg::ST_FIN;
      end
      asdc_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (last_step) begin
          state_next = asdc_pkg::ST_FIN;
        end
      end
      asdc_pkg::ST_FIN: begin
        // wait until the result register is free
        if (!out_full || out_ready) begin
          cmd.fin    = 1'b1;
          state_next = asdc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = asdc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.fin) begin
      out_full_next = 1'b1;
    end else if (out_ready) begin
      out_full_next = 1'b0;
    end else begin
      out_full_next = out_full;
    end
  end

  assign out_valid = out_full;

endmodule
